FILE: src/assert_macros.svh
// Assertion helpers for the block that carries concurrent checks, moving_average_filter.
// Stand-alone header; expects a clock and an active-low reset name at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/maf_pkg.sv
// Shared types, widths and helpers of the moving average filter.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package maf_pkg;

	localparam int MAX_WINDOW   = 256;
	localparam int SAMPLE_BITS  = 24;
	localparam int CFG_BITS     = 9;
	localparam int PTR_BITS     = $clog2(MAX_WINDOW);
	localparam int FILL_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
	localparam int CMD_DEPTH    = 4;
	localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic [FILL_BITS-1:0]          fill_t;
	typedef logic [PTR_BITS-1:0]           ptr_t;

	// How the back end updates the running sum for one beat.
	typedef enum logic [1:0] {
		OP_GROW,      // window not yet full: add the new sample
		OP_SLIDE,     // window full: add the new sample, drop the oldest
		OP_RESTART,   // new record: the sum restarts at the new sample
		OP_RECOMPUTE  // window length changed: sum the ring again
	} op_t;

	typedef struct packed {
		sample_t sample;
		op_t     op;
		ptr_t    wp;       // ring slot that receives the sample
		ptr_t    evict;    // slot of the sample that leaves the window
		fill_t   count;    // samples in the window after this beat
		fill_t   divisor;  // effective window length
	} cmd_t;

	typedef struct packed {
		fill_t fill;
		logic  dirty;
	} front_stat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic sum_t sext_sum(input sample_t s);
		return {{(SUM_BITS - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
	endfunction

endpackage

FILE: src/moving_average_filter.sv
// Boxcar moving average. Each beat leaves the command queue in S_IDLE; a sliding beat
// then passes S_EVICT, and the first beat after a window length change re-reads its
// window in S_SUM to rebuild the sum. S_DIV_GO then starts the 32-step divider, S_DIV_WAIT
// waits for it, S_RESULT registers the mean; up to four beats queue in front of it. The back
// end takes one beat at a time, waiting while a result is not popped. arst_n clears pointers, fill count,
// running sum and flags; the ring is not cleared, as only slots of the current record are read.
`include "assert_macros.svh"

module moving_average_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          window_length_we,
	input  logic [maf_pkg::CFG_BITS-1:0]  window_length,
	input  logic                          push,
	output logic                          full,
	input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                          start_req,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [maf_pkg::SAMPLE_BITS-1:0] mean
);

	logic                  accept;
	logic                  cmd_push;
	logic                  cmd_pop;
	maf_pkg::cmd_t         cmd_in;
	maf_pkg::cmd_t         cmd_out;
	maf_pkg::front_stat_t  front_stat;
	maf_pkg::fifo_stat_t   fifo_stat;
	logic                  res_valid;
	logic                  fill_is_one;

	assign full   = fifo_stat.full;
	assign accept = push && !fifo_stat.full;
	assign empty  = !res_valid;

	maf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (window_length_we),
		.cfg_data  (window_length),
		.in_valid  (accept),
		.in_sample (sample),
		.in_start  (start_req),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.stat      (front_stat)
	);

	maf_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.stat   (fifo_stat)
	);

	maf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (fifo_stat.empty),
		.cmd_pop   (cmd_pop),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res_mean  (mean)
	);

	assign fill_is_one = (front_stat.fill == maf_pkg::FILL_BITS'(1));

	// An accepted beat into an empty queue is still queued in the following cycle.
	`ASSERT_NEXT(a_beat_queued, clk, arst_n, accept && fifo_stat.empty, !fifo_stat.empty, "beat lost")
	// A record start leaves exactly one sample in the record.
	`ASSERT_NEXT(a_start_fill, clk, arst_n, accept && start_req, fill_is_one, "fill not restarted")
	// A window length write always marks the running sum stale; the next beat rebuilds it unless it starts a record.
	`ASSERT_NEXT(a_cfg_dirty, clk, arst_n, window_length_we, front_stat.dirty, "sum not marked stale")

endmodule

FILE: src/maf_front.sv
// Front end: holds the window length register, tracks record fill and ring pointer,
// and turns each accepted sample into a command for the back end. Uses maf_pkg.
module maf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [maf_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  maf_pkg::sample_t         in_sample,
	input  logic                     in_start,
	output logic                     cmd_push,
	output maf_pkg::cmd_t            cmd,
	output maf_pkg::front_stat_t     stat
);

	logic [maf_pkg::CFG_BITS-1:0] wl_q;
	maf_pkg::fill_t               w_eff;
	maf_pkg::fill_t               fill_q;
	maf_pkg::fill_t               fill_before;
	maf_pkg::fill_t               fill_new;
	maf_pkg::ptr_t                wp_q;
	logic                         dirty_q;

	// Zero acts as one, anything beyond the ring acts as the full ring.
	always_comb begin
		if (wl_q == '0) begin
			w_eff = maf_pkg::FILL_BITS'(1);
		end else if (wl_q > maf_pkg::CFG_BITS'(maf_pkg::MAX_WINDOW)) begin
			w_eff = maf_pkg::FILL_BITS'(maf_pkg::MAX_WINDOW);
		end else begin
			w_eff = maf_pkg::FILL_BITS'(wl_q);
		end
	end

	assign fill_before = in_start ? '0 : fill_q;
	assign fill_new    = (fill_before == maf_pkg::FILL_BITS'(maf_pkg::MAX_WINDOW)) ?
		fill_before : fill_before + maf_pkg::FILL_BITS'(1);

	assign cmd_push = in_valid;

	always_comb begin
		cmd.sample  = in_sample;
		cmd.wp      = wp_q;
		cmd.evict   = wp_q - w_eff[maf_pkg::PTR_BITS-1:0];
		cmd.count   = (w_eff < fill_new) ? w_eff : fill_new;
		cmd.divisor = w_eff;
		if (in_start) begin
			cmd.op = maf_pkg::OP_RESTART;
		end else if (dirty_q) begin
			cmd.op = maf_pkg::OP_RECOMPUTE;
		end else if (fill_before >= w_eff) begin
			cmd.op = maf_pkg::OP_SLIDE;
		end else begin
			cmd.op = maf_pkg::OP_GROW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= maf_pkg::CFG_BITS'(1);
			fill_q  <= '0;
			wp_q    <= '0;
			dirty_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_data;
			end
			if (in_valid) begin
				fill_q <= fill_new;
				wp_q   <= wp_q + maf_pkg::PTR_BITS'(1);
			end
			// A new window length makes the running sum stale until it is rebuilt.
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (in_valid) begin
				dirty_q <= 1'b0;
			end
		end
	end

	assign stat.fill  = fill_q;
	assign stat.dirty = dirty_q;

endmodule

FILE: src/maf_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Uses maf_pkg for the command type and depth.
module maf_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  maf_pkg::cmd_t        wdata,
	input  logic                 pop,
	output maf_pkg::cmd_t        rdata,
	output maf_pkg::fifo_stat_t  stat
);

	maf_pkg::cmd_t                    mem_q [maf_pkg::CMD_DEPTH];
	logic [maf_pkg::CMD_PTR_BITS-1:0] wr_ptr_q;
	logic [maf_pkg::CMD_PTR_BITS-1:0] rd_ptr_q;
	logic [maf_pkg::CMD_CNT_BITS-1:0] cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign stat.full  = (cnt_q == maf_pkg::CMD_CNT_BITS'(maf_pkg::CMD_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + maf_pkg::CMD_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + maf_pkg::CMD_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + maf_pkg::CMD_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - maf_pkg::CMD_CNT_BITS'(1);
			end
		end
	end

endmodule

FILE: src/maf_div.sv
// Bit-serial signed divider: window sum over window length, truncated toward zero.
// One quotient bit per cycle over the sum width. Uses maf_pkg for widths.
module maf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  maf_pkg::sum_t     dividend,
	input  maf_pkg::fill_t    divisor,
	output logic              done,
	output maf_pkg::sample_t  quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic                             neg_q;
	logic [maf_pkg::SUM_BITS-1:0]     mag_q;
	logic [maf_pkg::SUM_BITS-1:0]     quo_q;
	maf_pkg::fill_t                   rem_q;
	logic [maf_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [maf_pkg::FILL_BITS:0]      trial;
	logic                             fits;
	logic [maf_pkg::SUM_BITS-1:0]     dividend_mag;
	logic [maf_pkg::SAMPLE_BITS-1:0]  quo_low;

	assign dividend_mag = dividend[maf_pkg::SUM_BITS-1] ?
		(~dividend + maf_pkg::SUM_BITS'(1)) : dividend;
	assign trial = {rem_q, mag_q[maf_pkg::SUM_BITS-1]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + maf_pkg::DIV_CNT_BITS'(1);
				if (cnt_q == maf_pkg::DIV_CNT_BITS'(maf_pkg::SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring step: the remainder always stays below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[maf_pkg::SUM_BITS-1];
			mag_q <= dividend_mag;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[maf_pkg::SUM_BITS-2:0], 1'b0};
			quo_q <= {quo_q[maf_pkg::SUM_BITS-2:0], fits};
			if (fits) begin
				rem_q <= maf_pkg::FILL_BITS'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[maf_pkg::FILL_BITS-1:0];
			end
		end
	end

	assign quo_low  = quo_q[maf_pkg::SAMPLE_BITS-1:0];
	assign quotient = neg_q ? (~quo_low + maf_pkg::SAMPLE_BITS'(1)) : quo_low;
	assign done     = done_q;

endmodule

FILE: src/maf_back.sv
// Back end: sample ring, running sum update, divider control and result register.
// Uses maf_pkg and instantiates maf_div.
module maf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  maf_pkg::cmd_t     cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              res_pop,
	output logic              res_valid,
	output maf_pkg::sample_t  res_mean
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVICT,
		S_SUM,
		S_DIV_GO,
		S_DIV_WAIT,
		S_RESULT
	} state_t;

	state_t            state_q;
	maf_pkg::cmd_t     cmd_q;
	maf_pkg::sum_t     sum_q;
	maf_pkg::fill_t    iss_q;
	logic              rd_vld_q;
	logic              res_valid_q;
	maf_pkg::sample_t  mean_q;

	maf_pkg::sample_t  ring [maf_pkg::MAX_WINDOW];
	maf_pkg::sample_t  rd_data_q;
	logic              mem_we;
	maf_pkg::ptr_t     mem_waddr;
	maf_pkg::sample_t  mem_wdata;
	logic              mem_re;
	maf_pkg::ptr_t     mem_raddr;
	logic              issue;

	logic              div_start;
	logic              div_done;
	maf_pkg::sample_t  div_quot;

	assign cmd_pop = (state_q == S_IDLE) && !cmd_empty;
	assign issue   = (state_q == S_SUM) && (iss_q < cmd_q.count);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cmd.wp;
		mem_wdata = cmd.sample;
		mem_re    = 1'b0;
		mem_raddr = cmd.evict;
		if (cmd_pop) begin
			// On a slide the leaving sample may share the slot, so it is read first.
			if (cmd.op == maf_pkg::OP_SLIDE) begin
				mem_re = 1'b1;
			end else begin
				mem_we = 1'b1;
			end
		end else if (state_q == S_EVICT) begin
			mem_we    = 1'b1;
			mem_waddr = cmd_q.wp;
			mem_wdata = cmd_q.sample;
		end else if (issue) begin
			mem_re    = 1'b1;
			mem_raddr = cmd_q.wp - iss_q[maf_pkg::PTR_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= ring[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			sum_q       <= '0;
			iss_q       <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			mean_q      <= '0;
		end else begin
			rd_vld_q <= issue;
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						iss_q <= '0;
						case (cmd.op)
							maf_pkg::OP_SLIDE: begin
								state_q <= S_EVICT;
							end
							maf_pkg::OP_RESTART: begin
								sum_q   <= maf_pkg::sext_sum(cmd.sample);
								state_q <= S_DIV_GO;
							end
							maf_pkg::OP_RECOMPUTE: begin
								sum_q   <= '0;
								state_q <= S_SUM;
							end
							default: begin
								sum_q   <= sum_q + maf_pkg::sext_sum(cmd.sample);
								state_q <= S_DIV_GO;
							end
						endcase
					end
				end
				S_EVICT: begin
					sum_q   <= sum_q + maf_pkg::sext_sum(cmd_q.sample)
						- maf_pkg::sext_sum(rd_data_q);
					state_q <= S_DIV_GO;
				end
				S_SUM: begin
					if (issue) begin
						iss_q <= iss_q + maf_pkg::FILL_BITS'(1);
					end
					if (rd_vld_q) begin
						sum_q <= sum_q + maf_pkg::sext_sum(rd_data_q);
					end else if (!issue) begin
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!res_valid_q || res_pop) begin
						res_valid_q <= 1'b1;
						mean_q      <= div_quot;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign div_start = (state_q == S_DIV_GO);

	maf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cmd_q.divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign res_valid = res_valid_q;
	assign res_mean  = mean_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the boxcar moving average filter.
// Depends on maf_pkg and moving_average_filter; a built-in predictor checks every mean.
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		maf_pkg::sample_t sample;
		logic             start;
	} beat_t;

	typedef enum {
		POP_ALWAYS,
		POP_RANDOM,
		POP_PERIODIC
	} pop_pattern_t;

	typedef enum {
		STYLE_RANDOM,
		STYLE_TOP,
		STYLE_BOTTOM,
		STYLE_SMALL
	} sample_style_t;

	localparam int SAMPLE_MAX = 8388607;
	localparam int SAMPLE_MIN = -8388608;
	localparam int RANDOM_PHASES = 12;
	localparam int BEATS_PER_PHASE = 128;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             window_length_we = 1'b0;
	logic [maf_pkg::CFG_BITS-1:0]     window_length = '0;
	logic                             push = 1'b0;
	logic                             full;
	maf_pkg::sample_t                 sample = '0;
	logic                             start_req = 1'b0;
	logic                             empty;
	logic                             pop = 1'b0;
	maf_pkg::sample_t                 mean;

	beat_t            pending_beats[$];
	maf_pkg::sample_t mean_expected[$];
	int               mismatch_count = 0;
	int               record_left = 0;

	// Predictor state: sample history, write slot, record fill and window length.
	maf_pkg::sample_t             history[maf_pkg::MAX_WINDOW];
	maf_pkg::ptr_t                filter_wp = '0;
	int                           filter_fill = 0;
	logic [maf_pkg::CFG_BITS-1:0] filter_window = maf_pkg::CFG_BITS'(1);

	int           burst_left = 0;
	int           gap_left = 0;
	pop_pattern_t pop_pattern = POP_ALWAYS;
	int           pattern_left = 0;
	int           pop_period = 1;
	int           pop_phase = 0;

	moving_average_filter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_length_we (window_length_we),
		.window_length    (window_length),
		.push             (push),
		.full             (full),
		.sample           (sample),
		.start_req        (start_req),
		.empty            (empty),
		.pop              (pop),
		.mean             (mean)
	);

	always #5 clk = ~clk;

	// Stores one sample and returns the truncated mean of the current window.
	function automatic maf_pkg::sample_t next_mean(input maf_pkg::sample_t s,
						     input logic new_record);
		int            eff;
		int            n;
		longint        acc;
		maf_pkg::ptr_t slot;
		if (filter_window == '0)
			eff = 1;
		else if (int'(filter_window) > maf_pkg::MAX_WINDOW)
			eff = maf_pkg::MAX_WINDOW;
		else
			eff = int'(filter_window);
		if (new_record)
			filter_fill = 0;
		history[filter_wp] = s;
		filter_wp = filter_wp + maf_pkg::PTR_BITS'(1);
		if (filter_fill < maf_pkg::MAX_WINDOW)
			filter_fill++;
		n = (eff < filter_fill) ? eff : filter_fill;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			slot = maf_pkg::ptr_t'(int'(filter_wp) - 1 - i);
			acc += history[slot];
		end
		return maf_pkg::sample_t'(acc / eff);
	endfunction

	// Sender: bursts of beats with random gaps, fed from pending_beats.
	always @(posedge clk or negedge arst_n) begin
		beat_t b;
		logic  drive_push;
		if (!arst_n) begin
			push <= 1'b0;
			sample <= '0;
			start_req <= 1'b0;
			filter_wp = '0;
			filter_fill = 0;
			filter_window = maf_pkg::CFG_BITS'(1);
			burst_left = $urandom_range(1, 16);
			gap_left = 0;
		end else begin
			if (window_length_we)
				filter_window = window_length;
			if (push && !full)
				mean_expected = {mean_expected, next_mean(sample, start_req)};
			if (!(push && full)) begin
				drive_push = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_beats.size() > 0) begin
					b = pending_beats[0];
					pending_beats.delete(0);
					sample <= b.sample;
					start_req <= b.start;
					drive_push = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
					end
				end
				push <= drive_push;
			end
		end
	end

	// Receiver: checks each result beat and stalls on a changing pattern.
	always @(posedge clk or negedge arst_n) begin
		maf_pkg::sample_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pattern_left = 0;
		end else begin
			if (pop && !empty) begin
				if (mean_expected.size() == 0) begin
					$display("%t: unexpected result, expected none, got %0d", $time, mean);
					mismatch_count++;
				end else begin
					want = mean_expected[0];
					mean_expected.delete(0);
					if (mean !== want) begin
						$display("%t: mean mismatch, expected %0d, got %0d",
							 $time, want, mean);
						mismatch_count++;
					end
				end
			end
			if (pattern_left == 0) begin
				pop_pattern = pop_pattern_t'($urandom_range(0, 2));
				pattern_left = $urandom_range(50, 400);
				pop_period = $urandom_range(2, 12);
				pop_phase = 0;
			end else begin
				pattern_left--;
			end
			case (pop_pattern)
				POP_ALWAYS: begin
					pop <= 1'b1;
				end
				POP_RANDOM: begin
					pop <= 1'($urandom_range(0, 1));
				end
				default: begin
					pop <= (pop_phase == 0);
					pop_phase = (pop_phase + 1) % pop_period;
				end
			endcase
		end
	end

	task automatic queue_beat(input int s, input logic start);
		beat_t b;
		b.sample = maf_pkg::sample_t'(s);
		b.start = start;
		pending_beats = {pending_beats, b};
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_beats.size() != 0 || push || mean_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_window(input int value);
		wait_drained();
		window_length_we <= 1'b1;
		window_length <= maf_pkg::CFG_BITS'(value);
		@(posedge clk);
		window_length_we <= 1'b0;
	endtask

	// Records of random length; the sample style is kept for a whole phase so
	// that sums of extreme values build up over full windows.
	task automatic queue_random_beats(input int count);
		sample_style_t style;
		int            s;
		logic          start;
		style = sample_style_t'($urandom_range(0, 3));
		for (int i = 0; i < count; i++) begin
			start = 1'b0;
			if (record_left == 0) begin
				start = 1'b1;
				record_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
									  : $urandom_range(1, 40);
			end
			record_left--;
			if ($urandom_range(0, 15) == 0)
				s = $urandom;
			else
				case (style)
					STYLE_TOP:    s = SAMPLE_MAX;
					STYLE_BOTTOM: s = SAMPLE_MIN;
					STYLE_SMALL:  s = $signed($urandom_range(0, 20)) - 10;
					default:      s = $urandom;
				endcase
			queue_beat(s, start);
		end
	endtask

	initial begin
		int windows[RANDOM_PHASES];
		windows = '{2, 256, 0, 511, 37, 1, 257, 0, 3, 255, 0, 16};
		windows[7] = $urandom_range(1, 511);
		windows[10] = $urandom_range(1, 64);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_window(1);
		queue_beat(SAMPLE_MAX, 1'b1);
		queue_beat(SAMPLE_MIN, 1'b0);
		queue_beat(-1, 1'b0);
		queue_beat(1, 1'b0);
		queue_beat(0, 1'b0);

		// A zero window behaves as a window of one.
		set_window(0);
		queue_beat(-5, 1'b0);
		queue_beat(SAMPLE_MAX, 1'b0);

		// Short record still divides by the full window, rounding toward zero.
		set_window(4);
		queue_beat(7, 1'b1);
		queue_beat(-14, 1'b0);
		repeat (4) queue_beat(SAMPLE_MIN, 1'b0);
		queue_beat(5, 1'b1);
		queue_beat(-3, 1'b0);

		// Oversized window clamps to the ring size and applies to the held record.
		set_window(511);
		queue_beat(SAMPLE_MAX, 1'b0);
		queue_beat(SAMPLE_MAX, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_window(windows[p]);
			queue_random_beats(BEATS_PER_PHASE);
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && mean_expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
